/* rtl/isl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants of the inverse-square light map
// table sizes, field widths, source entry layout and sequencer states
// ----------------------------------------------------------------------------
package isl_pkg;

  // table and screen sizes
  localparam int MaxSources   = 8;
  localparam int ScreenWidth  = 1024;
  localparam int ScreenHeight = 1024;
  localparam int AlphaMax     = 255;

  // field widths
  localparam int PixW   = 10;
  localparam int CoordW = 12;
  localparam int StrW   = 16;
  localparam int AlphaW = 8;

  // datapath widths
  localparam int DiffW = CoordW + 1;   // signed pixel minus source coordinate
  localparam int AbsW  = CoordW;       // magnitude of that difference
  localparam int ProdW = 2 * AbsW;     // one square
  localparam int DistW = ProdW + 1;    // sum of two squares

  // table indexing
  localparam int IdxW   = (MaxSources > 1) ? $clog2(MaxSources) : 1;
  localparam int CountW = $clog2(MaxSources + 1);

  // divider step count
  localparam int DivSteps = StrW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // request type codes
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [StrW-1:0]   strength;
  } source_t;

  localparam int SourceW = $bits(source_t);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SQX,
    ST_SQY,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

/* rtl/inverse_square_light_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_square_light_map: light level of a pixel from a table of sources
// load requests append sources; pixel requests walk the table in load order
// and report min(strength / squared distance, 255) of the last covering one
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  --------------------------------
//  in       sink       in_valid_i / in_stall_o  req_type, source_x, source_y,
//                                               source_strength, pixel_row/col
//  out      source     out_valid_o / out_stall_i alpha, covered
//
//  a load request gives no result; a pixel request reads the stored sources in
//  turn and, for each covering source, squares the distance and runs the
//  16-step shared divider, skipped when the pixel sits on the source
//  in_stall_o stays high while a pixel request is walked; a finished result
//  waits in the output register, so the next request is taken meanwhile
//  reset empties the table; the table contents need no clearing
//
module inverse_square_light_map (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    req_type_i,
  input  logic signed [isl_pkg::CoordW-1:0]       source_x_i,
  input  logic signed [isl_pkg::CoordW-1:0]       source_y_i,
  input  logic        [isl_pkg::StrW-1:0]         source_strength_i,
  input  logic        [isl_pkg::PixW-1:0]         pixel_row_i,
  input  logic        [isl_pkg::PixW-1:0]         pixel_col_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic        [isl_pkg::AlphaW-1:0]       alpha_o,
  output logic                                    covered_o
);

  // sequencer and table state
  isl_pkg::state_e              state_q, state_d;
  logic [isl_pkg::CountW-1:0]   count_q;
  logic [isl_pkg::IdxW-1:0]     idx_q;

  // per-request working registers
  logic [isl_pkg::PixW-1:0]     row_q, col_q;
  logic [isl_pkg::AbsW-1:0]     dx_q, dy_q;
  logic [isl_pkg::DistW-1:0]    sum_q;
  logic [isl_pkg::AlphaW-1:0]   alpha_q;
  logic                         covered_q;

  // output register
  logic                         out_valid_q;
  logic [isl_pkg::AlphaW-1:0]   out_alpha_q;
  logic                         out_covered_q;

  // source table
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [isl_pkg::SourceW-1:0]  ram_rd_data;
  isl_pkg::source_t             wr_ent;
  isl_pkg::source_t             ent;

  // shared divider
  logic                         div_start;
  logic [isl_pkg::StrW-1:0]     div_quo;
  isl_pkg::div_status_t         div_st;

  // datapath signals
  logic                         in_take;
  logic                         off_screen;
  logic                         table_full;
  logic signed [isl_pkg::DiffW-1:0] drow, dcol;
  logic [isl_pkg::AbsW-1:0]     abs_row, abs_col;
  logic                         hit;
  logic                         mul_sel;
  logic [isl_pkg::AbsW-1:0]     mul_a;
  logic [isl_pkg::ProdW-1:0]    prod;
  logic                         sum_zero;
  logic                         last;
  logic                         adv;
  logic                         out_load;
  logic [isl_pkg::AlphaW-1:0]   level;

  assign in_take    = in_valid_i && !in_stall_o;
  assign table_full = count_q >= isl_pkg::CountW'(isl_pkg::MaxSources);
  assign off_screen =
    (isl_pkg::DiffW'(pixel_row_i) >= isl_pkg::DiffW'(isl_pkg::ScreenHeight)) ||
    (isl_pkg::DiffW'(pixel_col_i) >= isl_pkg::DiffW'(isl_pkg::ScreenWidth));

  assign wr_ent.x        = source_x_i;
  assign wr_ent.y        = source_y_i;
  assign wr_ent.strength = source_strength_i;
  assign ram_wr_en       = in_take && (req_type_i == isl_pkg::ReqLoad) && !table_full;

  isl_ram #(
    .Width (isl_pkg::SourceW),
    .Depth (isl_pkg::MaxSources)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (count_q[isl_pkg::IdxW-1:0]),
    .wr_data_i (wr_ent),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (ram_rd_data)
  );

  assign ent = isl_pkg::source_t'(ram_rd_data);

  // reach test: |pixel - source| strictly below strength on both axes
  assign drow = $signed(isl_pkg::DiffW'(row_q)) - $signed({ent.x[isl_pkg::CoordW-1], ent.x});
  assign dcol = $signed(isl_pkg::DiffW'(col_q)) - $signed({ent.y[isl_pkg::CoordW-1], ent.y});

  always_comb begin
    abs_row = drow[isl_pkg::DiffW-1] ? isl_pkg::AbsW'(-drow) : drow[isl_pkg::AbsW-1:0];
    abs_col = dcol[isl_pkg::DiffW-1] ? isl_pkg::AbsW'(-dcol) : dcol[isl_pkg::AbsW-1:0];
    hit     = (isl_pkg::StrW'(abs_row) < ent.strength) &&
              (isl_pkg::StrW'(abs_col) < ent.strength);
  end

  // one multiplier, squares dx then dy
  assign mul_a = mul_sel ? dy_q : dx_q;
  assign prod  = mul_a * mul_a;

  isl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ent.strength),
    .divisor_i  (sum_q),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  // clamp the quotient to the alpha range
  assign level = (div_quo > isl_pkg::StrW'(isl_pkg::AlphaMax)) ?
                 isl_pkg::AlphaW'(isl_pkg::AlphaMax) : div_quo[isl_pkg::AlphaW-1:0];

  assign sum_zero = (sum_q == '0);
  assign last     = (isl_pkg::CountW'(idx_q) + isl_pkg::CountW'(1)) >= count_q;

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != isl_pkg::ST_IDLE);
    ram_rd_en  = (state_q == isl_pkg::ST_READ);
    mul_sel    = (state_q == isl_pkg::ST_SQY);
    div_start  = (state_q == isl_pkg::ST_START) && !sum_zero;
    adv        = ((state_q == isl_pkg::ST_CHECK) && !hit) ||
                 ((state_q == isl_pkg::ST_START) && sum_zero) ||
                 ((state_q == isl_pkg::ST_DIV) && div_st.done);
    out_load   = (state_q == isl_pkg::ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isl_pkg::ST_IDLE: begin
        if (in_take && (req_type_i == isl_pkg::ReqQuery)) begin
          if ((count_q == '0) || off_screen) begin
            state_d = isl_pkg::ST_FIN;
          end else begin
            state_d = isl_pkg::ST_READ;
          end
        end
      end
      isl_pkg::ST_READ:  state_d = isl_pkg::ST_CHECK;
      isl_pkg::ST_CHECK: begin
        if (hit) begin
          state_d = isl_pkg::ST_SQX;
        end else begin
          state_d = last ? isl_pkg::ST_FIN : isl_pkg::ST_READ;
        end
      end
      isl_pkg::ST_SQX:   state_d = isl_pkg::ST_SQY;
      isl_pkg::ST_SQY:   state_d = isl_pkg::ST_START;
      isl_pkg::ST_START: begin
        if (sum_zero) begin
          state_d = last ? isl_pkg::ST_FIN : isl_pkg::ST_READ;
        end else begin
          state_d = isl_pkg::ST_DIV;
        end
      end
      isl_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_d = last ? isl_pkg::ST_FIN : isl_pkg::ST_READ;
        end
      end
      isl_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = isl_pkg::ST_IDLE;
        end
      end
      default: state_d = isl_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isl_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_wr_en) begin
        count_q <= count_q + isl_pkg::CountW'(1);
      end
      if (in_take) begin
        idx_q <= '0;
      end else if (adv && !last) begin
        idx_q <= idx_q + isl_pkg::IdxW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      row_q     <= pixel_row_i;
      col_q     <= pixel_col_i;
      alpha_q   <= '0;
      covered_q <= 1'b0;
    end
    if (state_q == isl_pkg::ST_CHECK) begin
      dx_q <= abs_row;
      dy_q <= abs_col;
    end
    if (state_q == isl_pkg::ST_SQX) begin
      sum_q <= isl_pkg::DistW'(prod);
    end
    if (state_q == isl_pkg::ST_SQY) begin
      sum_q <= sum_q + isl_pkg::DistW'(prod);
    end
    // source at distance zero gives full level
    if ((state_q == isl_pkg::ST_START) && sum_zero) begin
      alpha_q   <= isl_pkg::AlphaW'(isl_pkg::AlphaMax);
      covered_q <= 1'b1;
    end
    if ((state_q == isl_pkg::ST_DIV) && div_st.done) begin
      alpha_q   <= level;
      covered_q <= 1'b1;
    end
    if (out_load) begin
      out_alpha_q   <= alpha_q;
      out_covered_q <= covered_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_o     = out_alpha_q;
  assign covered_o   = out_covered_q;

  // table never holds more entries than it has rows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= isl_pkg::CountW'(isl_pkg::MaxSources))
    else $error("source count beyond table size");

  // only stored entries are read
  a_read_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == isl_pkg::ST_READ) |-> (isl_pkg::CountW'(idx_q) < count_q))
    else $error("read of an unstored table entry");

  // the divider works only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || div_st.done) |-> (state_q == isl_pkg::ST_DIV))
    else $error("divider active outside its wait state");

  // a new result appears only from the finish state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == isl_pkg::ST_FIN))
    else $error("result without a finished pixel request");

endmodule

/* rtl/isl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ram: generic single-port-write ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                         clk_i,
  input  logic                                         wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                             wr_data_i,
  input  logic                                         rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                             rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/isl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_div: restoring divider, one quotient bit per cycle
// divides the source strength by the squared distance
// ----------------------------------------------------------------------------
module isl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [isl_pkg::StrW-1:0]   dividend_i,
  input  logic [isl_pkg::DistW-1:0]  divisor_i,
  output logic [isl_pkg::StrW-1:0]   quotient_o,
  output isl_pkg::div_status_t       status_o
);

  logic [isl_pkg::DistW-1:0]   rem_q, rem_d;
  logic [isl_pkg::StrW-1:0]    quo_q, quo_d;
  logic [isl_pkg::DistW-1:0]   dvs_q;
  logic [isl_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [isl_pkg::DistW:0]     trial;
  logic                        ge;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, quo_q[isl_pkg::StrW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? isl_pkg::DistW'(trial - {1'b0, dvs_q}) : trial[isl_pkg::DistW-1:0];
    quo_d = {quo_q[isl_pkg::StrW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + isl_pkg::DivCntW'(1);
        if (cnt_q == isl_pkg::DivCntW'(isl_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

/* verif/tb_inverse_square_light_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverse_square_light_map: self-checking bench for the light map
// runs directed loads and queries that fill the source table, then random pixel
// requests, mostly near sources; a shadow table predicts alpha and coverage
// ----------------------------------------------------------------------------
module tb_inverse_square_light_map;

  localparam int CycleLimit = 1_000_000;
  localparam int RandQueries = 580;
  localparam int DrainCycles = 250;
  localparam int CalmLevel = 100;

  // one request as the driver presents it
  typedef struct packed {
    logic                              kind;
    logic signed [isl_pkg::CoordW-1:0] sx;
    logic signed [isl_pkg::CoordW-1:0] sy;
    logic        [isl_pkg::StrW-1:0]   strength;
    logic        [isl_pkg::PixW-1:0]   row;
    logic        [isl_pkg::PixW-1:0]   col;
  } light_req_t;

  // one pixel result
  typedef struct packed {
    logic [isl_pkg::AlphaW-1:0] alpha;
    logic                       covered;
  } light_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              req_type_i = isl_pkg::ReqLoad;
  logic signed [isl_pkg::CoordW-1:0] source_x_i = '0;
  logic signed [isl_pkg::CoordW-1:0] source_y_i = '0;
  logic        [isl_pkg::StrW-1:0]   source_strength_i = '0;
  logic        [isl_pkg::PixW-1:0]   pixel_row_i = '0;
  logic        [isl_pkg::PixW-1:0]   pixel_col_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic        [isl_pkg::AlphaW-1:0] alpha_o;
  logic                              covered_o;

  inverse_square_light_map u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .source_x_i        (source_x_i),
    .source_y_i        (source_y_i),
    .source_strength_i (source_strength_i),
    .pixel_row_i       (pixel_row_i),
    .pixel_col_i       (pixel_col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .alpha_o           (alpha_o),
    .covered_o         (covered_o)
  );

  // requests waiting for the driver, light levels waiting for the monitor
  light_req_t request_q[$];
  light_t     light_q[$];

  // shadow of the source table, updated as load requests are taken
  logic signed [isl_pkg::CoordW-1:0] lamp_x[isl_pkg::MaxSources];
  logic signed [isl_pkg::CoordW-1:0] lamp_y[isl_pkg::MaxSources];
  logic        [isl_pkg::StrW-1:0]   lamp_str[isl_pkg::MaxSources];
  int                                lamp_count = 0;

  // sources as planned at stimulus build time, used to aim pixel requests
  int aim_x[isl_pkg::MaxSources];
  int aim_y[isl_pkg::MaxSources];
  int aim_str[isl_pkg::MaxSources];
  int aim_count = 0;

  int errors = 0;
  int cycles = 0;
  int idle_left = 0;
  int hold_left = 0;
  light_req_t shown;

  // ---------------------------------------------------------------------------
  // predictor: walk the shadow table in load order, last covering source wins
  // ---------------------------------------------------------------------------
  function automatic light_t light_level(input logic [isl_pkg::PixW-1:0] row,
                                         input logic [isl_pkg::PixW-1:0] col);
    light_t lit;
    int rr, cc, sx, sy, reach, dx, dy, d2, lvl;
    lit = '{alpha: '0, covered: 1'b0};
    rr = int'(row);
    cc = int'(col);
    // off-screen pixels stay dark
    if (rr < isl_pkg::ScreenHeight && cc < isl_pkg::ScreenWidth) begin
      for (int i = 0; i < lamp_count; i++) begin
        sx = int'(lamp_x[i]);
        sy = int'(lamp_y[i]);
        reach = int'(lamp_str[i]);
        // strictly inside the square reach; zero strength never covers
        if (rr < sx + reach && rr > sx - reach && cc < sy + reach && cc > sy - reach) begin
          dx = (rr >= sx) ? rr - sx : sx - rr;
          dy = (cc >= sy) ? cc - sy : sy - cc;
          d2 = dx * dx + dy * dy;
          if (d2 == 0) begin
            lvl = isl_pkg::AlphaMax;
          end else begin
            lvl = reach / d2;
            if (lvl > isl_pkg::AlphaMax) lvl = isl_pkg::AlphaMax;
          end
          lit.alpha = lvl[isl_pkg::AlphaW-1:0];
          lit.covered = 1'b1;
        end
      end
    end
    return lit;
  endfunction

  // update the shadow table or queue the expected light level
  task automatic take_request(input light_req_t rq);
    if (rq.kind == isl_pkg::ReqLoad) begin
      // a full table ignores the load
      if (lamp_count < isl_pkg::MaxSources) begin
        lamp_x[lamp_count] = rq.sx;
        lamp_y[lamp_count] = rq.sy;
        lamp_str[lamp_count] = rq.strength;
        lamp_count++;
      end
    end else begin
      light_q = {light_q, light_level(rq.row, rq.col)};
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders; unused fields carry random bits
  // ---------------------------------------------------------------------------
  task automatic add_load(input int x, input int y, input int s);
    light_req_t rq;
    rq.kind = isl_pkg::ReqLoad;
    rq.sx = x[isl_pkg::CoordW-1:0];
    rq.sy = y[isl_pkg::CoordW-1:0];
    rq.strength = s[isl_pkg::StrW-1:0];
    rq.row = isl_pkg::PixW'($urandom());
    rq.col = isl_pkg::PixW'($urandom());
    request_q = {request_q, rq};
    if (aim_count < isl_pkg::MaxSources) begin
      aim_x[aim_count] = x;
      aim_y[aim_count] = y;
      aim_str[aim_count] = s;
      aim_count++;
    end
  endtask

  task automatic add_query(input int r, input int c);
    light_req_t rq;
    rq.kind = isl_pkg::ReqQuery;
    rq.sx = isl_pkg::CoordW'($urandom());
    rq.sy = isl_pkg::CoordW'($urandom());
    rq.strength = isl_pkg::StrW'($urandom());
    rq.row = r[isl_pkg::PixW-1:0];
    rq.col = c[isl_pkg::PixW-1:0];
    request_q = {request_q, rq};
  endtask

  function automatic int clamp_pix(input int v);
    if (v < 0) return 0;
    if (v > isl_pkg::ScreenWidth - 1) return isl_pkg::ScreenWidth - 1;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: present requests in order, holding each until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      // the shown request was taken at this edge
      if (in_valid_i) take_request(shown);
      if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() > 0) begin
        shown = request_q.pop_front();
        req_type_i <= shown.kind;
        source_x_i <= shown.sx;
        source_y_i <= shown.sy;
        source_strength_i <= shown.strength;
        pixel_row_i <= shown.row;
        pixel_col_i <= shown.col;
        in_valid_i <= 1'b1;
        // idle burst after this request is taken; none once the run nears its end
        if (request_q.size() >= CalmLevel && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 9);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (request_q.size() >= CalmLevel && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each taken result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    light_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (light_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual alpha %0d covered %0d",
                 $time, alpha_o, covered_o);
        errors++;
      end else begin
        want = light_q.pop_front();
        if (alpha_o !== want.alpha) begin
          $display("%0t: alpha mismatch: expected %0d, actual %0d", $time, want.alpha,
                   alpha_o);
          errors++;
        end
        if (covered_o !== want.covered) begin
          $display("%0t: covered mismatch: expected %0d, actual %0d", $time,
                   want.covered, covered_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int queries, i, span, r, c;

    // empty table gives a dark pixel
    add_query(0, 0);
    // zero strength at the most negative corner never covers
    add_load(-2048, -2048, 0);
    add_query(0, 0);
    add_load(100, 200, 50);
    add_query(100, 200);      // on the source itself
    add_query(101, 200);      // distance one, no clamp
    add_query(149, 200);      // inside reach, level rounds to zero
    add_query(150, 200);      // on the reach border, not covered
    // partly off screen, negative row coordinate
    add_load(-5, 1030, 40);
    add_query(0, 1023);
    add_query(34, 1023);
    add_load(700, 300, 300);
    add_query(700, 301);      // level above the clamp
    add_query(710, 310);
    add_load(300, 800, 400);
    add_load(900, 900, 16);
    add_load(1023, 0, 120);
    add_query(1023, 0);
    add_query(1023, 1023);
    add_load(2047, 2047, 1500);
    // table full: these loads are dropped
    add_load(-2048, 2047, 65535);
    add_load(2047, -2048, 65535);
    add_query(1023, 1023);
    add_query(600, 600);
    add_query(300, 800);

    // random part: mostly pixels near known sources, some spread, some loads
    queries = 0;
    while (queries < RandQueries) begin
      if ($urandom_range(0, 6) == 0) begin
        add_load(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                 int'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 9) < 6) begin
        i = $urandom_range(1, isl_pkg::MaxSources - 1);
        span = ((aim_str[i] > 40) ? 40 : aim_str[i]) + 2;
        r = clamp_pix(aim_x[i] + int'($urandom_range(0, 2 * span)) - span);
        c = clamp_pix(aim_y[i] + int'($urandom_range(0, 2 * span)) - span);
        add_query(r, c);
        queries++;
      end else begin
        add_query(int'($urandom_range(0, isl_pkg::ScreenHeight - 1)),
                  int'($urandom_range(0, isl_pkg::ScreenWidth - 1)));
        queries++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (light_q.size() > 0) @(posedge clk_i);
    // let any late extra result show up
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
